### hdl/rae_pkg.sv
// Shared types and constants for the region adjacency edge accumulator.
package rae_pkg;

  localparam int DEF_MAX_ROW       = 256;
  localparam int DEF_MAX_ROWS      = 256;
  localparam int DEF_EDGE_DEPTH    = 4096;
  localparam int DEF_AFFINITY_BITS = 16;

  localparam int LABEL_BITS = 32;
  localparam logic [23:0] COUNT_MAX = 24'hff_ffff;
  localparam logic [39:0] SUM_MAX   = 40'hff_ffff_ffff;

  typedef enum logic [1:0] {
    OP_VOXEL = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    CFG_ROW_LENGTH     = 2'd0,
    CFG_ROWS_PER_PLANE = 2'd1,
    CFG_EDGE_LIMIT     = 2'd2,
    CFG_UNUSED         = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    CMD_ACC   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } eng_cmd_t;

  typedef enum logic [1:0] {
    E_IDLE,
    E_LOOK,
    E_CMP,
    E_RDOUT
  } eng_state_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_UP,
    S_CAP,
    S_EDGE,
    S_WAIT,
    S_FIN
  } top_state_t;

  typedef struct packed {
    eng_cmd_t    cmd;
    logic [31:0] lab_a;
    logic [31:0] lab_b;
    logic [15:0] aff;
    logic [11:0] idx;
  } edge_req_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [23:0] cnt;
    logic [39:0] sum;
  } edge_res_t;

endpackage

### hdl/rae_plane_mem.sv
// Label plane store: one write port, one registered read port.
module rae_plane_mem #(
  parameter int DEPTH = rae_pkg::DEF_MAX_ROW * rae_pkg::DEF_MAX_ROWS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);
  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

### hdl/rae_edge_engine.sv
// Edge table: key, count and sum memories with a search and update sequencer.
module rae_edge_engine #(
  parameter int EDGE_DEPTH = rae_pkg::DEF_EDGE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  rae_pkg::edge_req_t  req,
  input  logic [12:0]         edge_limit,
  output logic                done,
  output rae_pkg::edge_res_t  res,
  output logic [12:0]         edges_found,
  output logic                overflow
);
  import rae_pkg::*;

  localparam int AW = (EDGE_DEPTH > 1) ? $clog2(EDGE_DEPTH) : 1;
  localparam int SW = $clog2(EDGE_DEPTH + 1);

  logic [63:0] key_mem [EDGE_DEPTH];
  logic [23:0] cnt_mem [EDGE_DEPTH];
  logic [39:0] sum_mem [EDGE_DEPTH];
  logic [63:0] key_q;
  logic [23:0] cnt_q;
  logic [39:0] sum_q;

  eng_state_t  state_r, state_nxt;
  logic [31:0] lo_r, hi_r;
  logic [15:0] aff_r;
  logic [SW-1:0] i_r, stored_r;
  logic        ovf_r, done_r, done_nxt;
  edge_res_t   res_r;

  logic [31:0] lo_in, hi_in, lim;
  logic        skip, idx_ok, full, at_end, hit;
  logic        we;
  logic [AW-1:0] raddr, waddr;
  logic [63:0] wkey;
  logic [23:0] wcnt;
  logic [39:0] wsum;
  logic [40:0] sum_inc;

  assign lo_in   = (req.lab_a < req.lab_b) ? req.lab_a : req.lab_b;
  assign hi_in   = (req.lab_a < req.lab_b) ? req.lab_b : req.lab_a;
  assign skip    = (req.lab_a == req.lab_b) || (lo_in == '0);
  assign idx_ok  = 32'(req.idx) < 32'(stored_r);
  assign lim     = (32'(edge_limit) > 32'(EDGE_DEPTH)) ? 32'(EDGE_DEPTH) : 32'(edge_limit);
  assign full    = 32'(stored_r) >= lim;
  assign at_end  = i_r >= stored_r;
  assign hit     = key_q == {lo_r, hi_r};
  assign sum_inc = {1'b0, sum_q} + 41'(aff_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      E_IDLE: begin
        if (start) begin
          if (req.cmd == CMD_ACC && !skip) state_nxt = E_LOOK;
          else if (req.cmd == CMD_READ && idx_ok) state_nxt = E_RDOUT;
        end
      end
      E_LOOK:  state_nxt = at_end ? E_IDLE : E_CMP;
      E_CMP:   state_nxt = hit ? E_IDLE : E_LOOK;
      E_RDOUT: state_nxt = E_IDLE;
      default: state_nxt = E_IDLE;
    endcase
  end

  always_comb begin
    done_nxt = 1'b0;
    we       = 1'b0;
    raddr    = i_r[AW-1:0];
    waddr    = i_r[AW-1:0];
    wkey     = {lo_r, hi_r};
    wcnt     = (cnt_q != COUNT_MAX) ? cnt_q + 24'd1 : cnt_q;
    wsum     = (sum_inc > 41'(SUM_MAX)) ? SUM_MAX : sum_inc[39:0];
    unique case (state_r)
      E_IDLE: begin
        raddr = AW'(req.idx);
        if (start) begin
          done_nxt = (req.cmd == CMD_CLEAR) || (req.cmd == CMD_ACC && skip) ||
                     (req.cmd == CMD_READ && !idx_ok);
        end
      end
      E_LOOK: begin
        done_nxt = at_end;
        if (at_end && !full) begin
          // append a new edge at the end of the table
          we    = 1'b1;
          waddr = stored_r[AW-1:0];
          wcnt  = 24'd1;
          wsum  = 40'(aff_r);
        end
      end
      E_CMP: begin
        done_nxt = hit;
        we       = hit;
      end
      E_RDOUT: done_nxt = 1'b1;
      default: done_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr] <= wkey;
      cnt_mem[waddr] <= wcnt;
      sum_mem[waddr] <= wsum;
    end
    key_q <= key_mem[raddr];
    cnt_q <= cnt_mem[raddr];
    sum_q <= sum_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= E_IDLE;
      stored_r <= '0;
      ovf_r    <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      unique case (state_r)
        E_IDLE: begin
          if (start) begin
            lo_r  <= lo_in;
            hi_r  <= hi_in;
            aff_r <= req.aff;
            i_r   <= '0;
            res_r <= '0;
            if (req.cmd == CMD_CLEAR) begin
              stored_r <= '0;
              ovf_r    <= 1'b0;
            end
          end
        end
        E_LOOK: begin
          if (at_end) begin
            if (full) ovf_r <= 1'b1;
            else stored_r <= stored_r + SW'(1);
          end
        end
        E_CMP: begin
          if (!hit) i_r <= i_r + SW'(1);
        end
        E_RDOUT: res_r <= '{1'b1, key_q[63:32], key_q[31:0], cnt_q, sum_q};
        default: ;
      endcase
    end
  end

  assign done        = done_r;
  assign res         = res_r;
  assign edges_found = 13'(32'(stored_r));
  assign overflow    = ovf_r;

  a_stored_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(stored_r) <= 32'(EDGE_DEPTH)) else $error("edge count beyond table depth");
  a_cmp_after_look: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == E_CMP |-> $past(state_r) == E_LOOK) else $error("compare without lookup");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> state_r == E_IDLE) else $error("done while busy");
  a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == E_CMP |-> i_r < stored_r) else $error("search past stored edges");
endmodule

### hdl/region_adjacency_edge_accumulator_top.sv
// Top level: voxel sequencer, raster position, configuration and result register.
// Voxel: each neighbour present is passed to the edge engine; one whose labels match or whose
//   lower label is background is skipped, else the stored edges are searched in order until
//   a hit or the end of the table. Read, clear and the unused opcode need no search.
// One item at a time: the next beat is taken the cycle after the result loads; the linear
//   search over the key memory read port sets the rate. Synchronous active-low reset clears
//   position, edge count, overflow and registers to defaults; memories keep contents.
module region_adjacency_edge_accumulator_top #(
  parameter int MAX_ROW       = rae_pkg::DEF_MAX_ROW,
  parameter int MAX_ROWS      = rae_pkg::DEF_MAX_ROWS,
  parameter int EDGE_DEPTH    = rae_pkg::DEF_EDGE_DEPTH,
  parameter int AFFINITY_BITS = rae_pkg::DEF_AFFINITY_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_label,
  input  logic [15:0] in_affinity_z,
  input  logic [15:0] in_affinity_y,
  input  logic [15:0] in_affinity_x,
  input  logic [11:0] in_entry_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_overflow,
  output logic [12:0] out_edges_found,
  output logic        out_entry_valid,
  output logic [31:0] out_edge_low,
  output logic [31:0] out_edge_high,
  output logic [23:0] out_contact_count,
  output logic [39:0] out_affinity_sum,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  import rae_pkg::*;

  localparam int CW  = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;
  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int PD  = MAX_ROW * MAX_ROWS;
  localparam int PAW = $clog2(PD);
  localparam logic [15:0] AMASK = (AFFINITY_BITS >= 16) ? 16'hffff :
                                  16'((1 << AFFINITY_BITS) - 1);

  top_state_t state_r, state_nxt;
  opcode_t    op_in, op_r;
  logic [31:0] lab_r, z_lab_r, up_lab_r, left_r;
  logic [15:0] az_r, ay_r, ax_r;
  logic [1:0]  phase_r;
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic        past_r;
  logic [8:0]  row_length_r, rows_per_plane_r;
  logic [12:0] edge_limit_r;

  logic        out_valid_r, ovf_q, ent_valid_q;
  logic [12:0] found_q;
  logic [31:0] lo_q, hi_q;
  logic [23:0] cnt_q;
  logic [39:0] sum_q;

  logic        accept, fin_go, cond, eng_start, eng_done, eng_ovf;
  edge_req_t   eng_req;
  edge_res_t   eng_res;
  logic [12:0] eng_found;
  logic [31:0] here, up, xs, ys, col_inc, row_inc;
  logic [PAW-1:0] plane_raddr;
  logic [31:0] plane_rdata;

  assign op_in     = opcode_t'(in_opcode);
  assign in_stall  = state_r != S_IDLE;
  assign accept    = in_valid && !in_stall;
  assign fin_go    = (state_r == S_FIN) && (!out_valid_r || !out_stall);
  assign cfg_ready = 1'b1;

  assign here = 32'(row_r) * MAX_ROW + 32'(col_r);
  assign up   = here - 32'(MAX_ROW);
  assign xs   = (row_length_r == '0) ? 32'd1 :
                (32'(row_length_r) > 32'(MAX_ROW)) ? 32'(MAX_ROW) : 32'(row_length_r);
  assign ys   = (rows_per_plane_r == '0) ? 32'd1 :
                (32'(rows_per_plane_r) > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) :
                32'(rows_per_plane_r);
  assign col_inc = 32'(col_r) + 32'd1;
  assign row_inc = 32'(row_r) + 32'd1;

  always_comb begin
    case (phase_r)
      2'd0:    cond = past_r;
      2'd1:    cond = row_r != '0;
      default: cond = col_r != '0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (op_in) inside
            OP_VOXEL:          state_nxt = S_RD_UP;
            OP_READ, OP_CLEAR: state_nxt = S_WAIT;
            default:           state_nxt = S_FIN;
          endcase
        end
      end
      S_RD_UP: state_nxt = S_CAP;
      S_CAP:   state_nxt = S_EDGE;
      S_EDGE: begin
        if (cond) state_nxt = S_WAIT;
        else if (phase_r == 2'd2) state_nxt = S_FIN;
      end
      S_WAIT: begin
        if (eng_done) state_nxt = (op_r != OP_VOXEL || phase_r == 2'd2) ? S_FIN : S_EDGE;
      end
      S_FIN:   if (fin_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    eng_start   = 1'b0;
    eng_req     = '{CMD_ACC, lab_r, left_r, ax_r, in_entry_index};
    plane_raddr = here[PAW-1:0];
    unique case (state_r)
      S_IDLE: begin
        eng_start   = accept && (op_in == OP_READ || op_in == OP_CLEAR);
        eng_req.cmd = (op_in == OP_READ) ? CMD_READ : CMD_CLEAR;
      end
      S_RD_UP: plane_raddr = up[PAW-1:0];
      S_EDGE: begin
        eng_start = cond;
        case (phase_r)
          2'd0: begin
            eng_req.lab_b = z_lab_r;
            eng_req.aff   = az_r;
          end
          2'd1: begin
            eng_req.lab_b = up_lab_r;
            eng_req.aff   = ay_r;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  rae_plane_mem #(.DEPTH(PD), .AW(PAW)) u_plane (
    .clk   (clk),
    .we    (fin_go && op_r == OP_VOXEL),
    .waddr (here[PAW-1:0]),
    .wdata (lab_r),
    .raddr (plane_raddr),
    .rdata (plane_rdata)
  );

  rae_edge_engine #(.EDGE_DEPTH(EDGE_DEPTH)) u_edges (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (eng_start),
    .req         (eng_req),
    .edge_limit  (edge_limit_r),
    .done        (eng_done),
    .res         (eng_res),
    .edges_found (eng_found),
    .overflow    (eng_ovf)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      col_r            <= '0;
      row_r            <= '0;
      past_r           <= 1'b0;
      left_r           <= '0;
      out_valid_r      <= 1'b0;
      row_length_r     <= 9'd256;
      rows_per_plane_r <= 9'd256;
      edge_limit_r     <= 13'd4096;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index_t'(cfg_index))
          CFG_ROW_LENGTH:     row_length_r     <= cfg_data[8:0];
          CFG_ROWS_PER_PLANE: rows_per_plane_r <= cfg_data[8:0];
          CFG_EDGE_LIMIT:     edge_limit_r     <= cfg_data;
          default: ;
        endcase
      end
      if (accept && op_in == OP_CLEAR) begin
        col_r  <= '0;
        row_r  <= '0;
        past_r <= 1'b0;
        left_r <= '0;
      end
      if (fin_go && op_r == OP_VOXEL) begin
        left_r <= lab_r;
        // advance the raster position, wrapping row and plane
        if (col_inc >= xs) begin
          col_r <= '0;
          if (row_inc >= ys) begin
            row_r  <= '0;
            past_r <= 1'b1;
          end else begin
            row_r <= row_inc[RW-1:0];
          end
        end else begin
          col_r <= col_inc[CW-1:0];
        end
      end
      if (fin_go) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= op_in;
      lab_r <= in_label;
      az_r  <= in_affinity_z & AMASK;
      ay_r  <= in_affinity_y & AMASK;
      ax_r  <= in_affinity_x & AMASK;
    end
    if (state_r == S_RD_UP) z_lab_r <= plane_rdata;
    if (state_r == S_CAP) begin
      up_lab_r <= plane_rdata;
      phase_r  <= 2'd0;
    end
    if (state_r == S_EDGE && !cond && phase_r != 2'd2) phase_r <= phase_r + 2'd1;
    if (state_r == S_WAIT && eng_done && op_r == OP_VOXEL && phase_r != 2'd2) begin
      phase_r <= phase_r + 2'd1;
    end
    if (fin_go) begin
      ovf_q       <= eng_ovf;
      found_q     <= eng_found;
      ent_valid_q <= (op_r == OP_READ) && eng_res.valid;
      lo_q        <= (op_r == OP_READ) ? eng_res.lo  : '0;
      hi_q        <= (op_r == OP_READ) ? eng_res.hi  : '0;
      cnt_q       <= (op_r == OP_READ) ? eng_res.cnt : '0;
      sum_q       <= (op_r == OP_READ) ? eng_res.sum : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_overflow      = ovf_q;
  assign out_edges_found   = found_q;
  assign out_entry_valid   = ent_valid_q;
  assign out_edge_low      = lo_q;
  assign out_edge_high     = hi_q;
  assign out_contact_count = cnt_q;
  assign out_affinity_sum  = sum_q;

  a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
    fin_go |=> out_valid_r) else $error("result beat not loaded");
  a_cap_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CAP |-> $past(state_r) == S_RD_UP) else $error("plane read order broken");
  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(col_r) < 32'(MAX_ROW)) else $error("column beyond row store");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WAIT |-> !eng_start) else $error("engine restarted while busy");
endmodule
